// ===== src/kwl_pkg.sv =====
// Shared types, character codes, token class codes and keyword table of the keyword lexer.
`default_nettype none

package kwl_pkg;

    localparam int PREFIX_DEPTH = 8;
    localparam int PREFIX_IDX_W = 3;
    localparam int KW_COUNT     = 12;

    typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

    // Source characters with a special meaning
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Token class codes
    localparam logic [4:0] CLS_IDENT    = 5'd0;
    localparam logic [4:0] CLS_NUMBER   = 5'd1;
    localparam logic [4:0] CLS_LOCAL    = 5'd2;
    localparam logic [4:0] CLS_FUNCTION = 5'd3;
    localparam logic [4:0] CLS_RETURN   = 5'd4;
    localparam logic [4:0] CLS_END      = 5'd5;
    localparam logic [4:0] CLS_IF       = 5'd6;
    localparam logic [4:0] CLS_THEN     = 5'd7;
    localparam logic [4:0] CLS_EQEQ     = 5'd8;
    localparam logic [4:0] CLS_LPAREN   = 5'd9;
    localparam logic [4:0] CLS_RPAREN   = 5'd10;
    localparam logic [4:0] CLS_ASSIGN   = 5'd11;
    localparam logic [4:0] CLS_PLUS     = 5'd12;
    localparam logic [4:0] CLS_MINUS    = 5'd13;
    localparam logic [4:0] CLS_STAR     = 5'd14;
    localparam logic [4:0] CLS_SLASH    = 5'd15;
    localparam logic [4:0] CLS_COMMA    = 5'd16;
    localparam logic [4:0] CLS_ENDMARK  = 5'd17;

    // Keyword and operator spellings, byte 0 is the first character
    localparam prefix_t KW_TEXT [KW_COUNT] = '{
        prefix_t'{0: "l", 1: "o", 2: "c", 3: "a", 4: "l", default: 8'h00},
        prefix_t'{0: "f", 1: "u", 2: "n", 3: "c", 4: "t", 5: "i", 6: "o", 7: "n"},
        prefix_t'{0: "r", 1: "e", 2: "t", 3: "u", 4: "r", 5: "n", default: 8'h00},
        prefix_t'{0: "e", 1: "n", 2: "d", default: 8'h00},
        prefix_t'{0: "i", 1: "f", default: 8'h00},
        prefix_t'{0: "t", 1: "h", 2: "e", 3: "n", default: 8'h00},
        prefix_t'{0: "=", 1: "=", default: 8'h00},
        prefix_t'{0: "=", default: 8'h00},
        prefix_t'{0: "+", default: 8'h00},
        prefix_t'{0: "-", default: 8'h00},
        prefix_t'{0: "*", default: 8'h00},
        prefix_t'{0: "/", default: 8'h00}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd8, 4'd6, 4'd3, 4'd2, 4'd4, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
    };

    localparam logic [4:0] KW_CLASS [KW_COUNT] = '{
        CLS_LOCAL, CLS_FUNCTION, CLS_RETURN, CLS_END, CLS_IF, CLS_THEN,
        CLS_EQEQ, CLS_ASSIGN, CLS_PLUS, CLS_MINUS, CLS_STAR, CLS_SLASH
    };

    // One result word
    typedef struct packed {
        logic [4:0] token_class;
        logic [4:0] token_length;
        logic       too_long;
        logic [7:0] token_index;
        logic       last;
    } result_t;

    // Results produced by one accepted character, a first and an optional second
    typedef struct packed {
        logic    a_valid;
        logic    b_valid;
        result_t a;
        result_t b;
    } tok_push_t;

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

endpackage

`default_nettype wire

// ===== src/keyword_token_lexer.sv =====
// Top level of the whitespace-delimited keyword lexer.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) takes one source byte per
//   word. Space, tab and newline end a pending token; '(' ')' ',' end it and
//   form a token of their own; ';' ends it and emits an end marker word with
//   m_tlast high, then clears the token counter. Empty tokens are never sent.
//   The master channel (m_tvalid/m_tready/m_tdata/m_tlast) gives one result
//   word per token: class, length, over-length flag and running index.
//   A result word is written into the result queue when the byte that
//   finishes the token is accepted, and is shown on the master side from there.
//   Throughput: one byte per cycle while s_tready is high. A byte that ends
//   a token and is itself punctuation or ';' makes two words, which drain at
//   one word per cycle while m_tready is high through a four-entry result
//   queue; s_tready stays high while the queue has room for two words.
//   When the receiver stalls, results wait in the queue and s_tready drops
//   once fewer than two entries are free; nothing is lost.
//   Reset (aresetn low, synchronous) empties the queue and clears the pending
//   token and the counter; no clearing pass is needed.
`default_nettype none

module keyword_token_lexer
    import kwl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 31,
    parameter int MAX_TOKENS    = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] token_class, [9:5] token_length,
                                   // [10] too_long, [18:11] token index, [23:19] zero
    output logic        m_tlast
);

    tok_push_t push;
    result_t   head;
    logic      room_for_two;
    logic      s_accept;

    // Accept a byte only while the queue can absorb both possible results
    assign s_tready = room_for_two;
    assign s_accept = s_tvalid && s_tready;

    kwl_tokenizer #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .MAX_TOKENS   (MAX_TOKENS)
    ) u_tokenizer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_valid(s_accept),
        .char_in   (s_tdata),
        .push      (push)
    );

    kwl_result_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .room_for_two(room_for_two),
        .head        (head),
        .head_valid  (m_tvalid),
        .head_ready  (m_tready)
    );

    // Pack the head word, first field in the lowest bits
    assign m_tdata = {5'd0, head.token_index, head.too_long,
                      head.token_length, head.token_class};
    assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== src/kwl_classify.sv =====
// Classifier of the pending token: keyword and operator match, number or identifier.
`default_nettype none

module kwl_classify
    import kwl_pkg::*;
#(
    parameter int LEN_W = 5
) (
    input  prefix_t          prefix,
    input  logic [LEN_W-1:0] pending_length,
    input  logic             overflowed,
    output logic [4:0]       token_class
);

    logic match;

    always_comb begin
        token_class = (prefix[0] >= CH_ZERO && prefix[0] <= CH_NINE) ? CLS_NUMBER : CLS_IDENT;
        match       = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            match = !overflowed && (pending_length == LEN_W'(KW_LEN[i]));
            for (int j = 0; j < PREFIX_DEPTH; j++) begin
                if ((j < int'(KW_LEN[i])) && (prefix[j] != KW_TEXT[i][j])) begin
                    match = 1'b0;
                end
            end
            if (match) begin
                token_class = KW_CLASS[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/kwl_tokenizer.sv =====
// Token state registers and per-character result generation.
`default_nettype none

module kwl_tokenizer
    import kwl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 31,
    parameter int MAX_TOKENS    = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       char_valid,
    input  logic [7:0] char_in,
    output tok_push_t  push
);

    localparam int         LEN_W   = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [7:0] CNT_CAP = 8'(((MAX_TOKENS - 1) > 255) ? 255 : (MAX_TOKENS - 1));

    prefix_t          prefix_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       cnt_reg, cnt_next;

    logic       is_ws, is_punct, is_semi, is_char;
    logic       flush;
    logic [7:0] cnt_flushed;
    logic [4:0] pend_class;
    logic [4:0] punct_class;
    result_t    flush_res, own_res;
    logic       own_valid;

    kwl_classify #(
        .LEN_W(LEN_W)
    ) u_classify (
        .prefix        (prefix_reg),
        .pending_length(len_reg),
        .overflowed    (ovf_reg),
        .token_class   (pend_class)
    );

    always_comb begin
        is_ws    = (char_in == CH_SPACE) || (char_in == CH_TAB) || (char_in == CH_NL);
        is_punct = (char_in == CH_LPAREN) || (char_in == CH_RPAREN) || (char_in == CH_COMMA);
        is_semi  = (char_in == CH_SEMI);
        is_char  = !(is_ws || is_punct || is_semi);

        flush       = char_valid && !is_char && (len_reg != '0);
        cnt_flushed = (flush && (cnt_reg < CNT_CAP)) ? cnt_reg + 8'd1 : cnt_reg;

        flush_res.token_class  = pend_class;
        flush_res.token_length = 5'(len_reg);
        flush_res.too_long     = ovf_reg;
        flush_res.token_index  = cnt_reg;
        flush_res.last         = 1'b0;

        if (char_in == CH_LPAREN) begin
            punct_class = CLS_LPAREN;
        end else if (char_in == CH_RPAREN) begin
            punct_class = CLS_RPAREN;
        end else begin
            punct_class = CLS_COMMA;
        end

        own_valid            = char_valid && (is_punct || is_semi);
        own_res.token_class  = is_semi ? CLS_ENDMARK : punct_class;
        own_res.token_length = is_semi ? 5'd0 : 5'd1;
        own_res.too_long     = 1'b0;
        own_res.token_index  = cnt_flushed;
        own_res.last         = is_semi;

        // Compact: the flushed token, if any, always goes first
        push.a_valid = flush || own_valid;
        push.b_valid = flush && own_valid;
        push.a       = flush ? flush_res : own_res;
        push.b       = own_res;

        len_next = len_reg;
        ovf_next = ovf_reg;
        cnt_next = cnt_reg;
        if (char_valid) begin
            if (is_semi) begin
                len_next = '0;
                ovf_next = 1'b0;
                cnt_next = '0;
            end else if (is_ws) begin
                len_next = '0;
                ovf_next = 1'b0;
                cnt_next = cnt_flushed;
            end else if (is_punct) begin
                len_next = '0;
                ovf_next = 1'b0;
                cnt_next = (cnt_flushed < CNT_CAP) ? cnt_flushed + 8'd1 : cnt_flushed;
            end else if (len_reg < LEN_W'(MAX_TOKEN_LEN)) begin
                len_next = len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            cnt_reg <= cnt_next;
        end
    end

    // Keep the first characters of the pending token
    always_ff @(posedge aclk) begin
        if (char_valid && is_char && (len_reg < LEN_W'(PREFIX_DEPTH))
                && (len_reg < LEN_W'(MAX_TOKEN_LEN))) begin
            prefix_reg[len_reg[PREFIX_IDX_W-1:0]] <= char_in;
        end
    end

    a_semi_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (char_valid && is_semi) |=> (len_reg == '0) && (cnt_reg == '0) && !ovf_reg)
        else $error("state not cleared after end marker");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_TOKEN_LEN))
        else $error("pending length beyond maximum");

endmodule

`default_nettype wire

// ===== src/kwl_result_queue.sv =====
// Four-entry result queue taking up to two results per cycle and giving one while head_ready is high.
`default_nettype none

module kwl_result_queue
    import kwl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  tok_push_t push,
    output logic      room_for_two,
    output result_t   head,
    output logic      head_valid,
    input  logic      head_ready
);

    result_t             mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_reg, wr_next;
    logic [RQ_PTR_W-1:0] rd_reg, rd_next;
    logic [RQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RQ_CNT_W-1:0] n_push;
    logic                pop;

    always_comb begin
        n_push       = RQ_CNT_W'(push.a_valid) + RQ_CNT_W'(push.b_valid);
        head_valid   = (cnt_reg != '0);
        head         = mem[rd_reg];
        pop          = head_valid && head_ready;
        room_for_two = (cnt_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
        wr_next      = wr_reg + RQ_PTR_W'(n_push);
        rd_next      = rd_reg + RQ_PTR_W'(pop);
        cnt_next     = cnt_reg + n_push - RQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.a_valid) begin
            mem[wr_reg] <= push.a;
        end
        if (push.b_valid) begin
            mem[wr_reg + RQ_PTR_W'(1)] <= push.b;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push.b_valid |-> push.a_valid && (cnt_reg <= RQ_CNT_W'(RQ_DEPTH - 2)))
        else $error("second result pushed out of order or into a full queue");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == RQ_CNT_W'(RQ_DEPTH)) || (cnt_reg == '0) || (wr_reg != rd_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire
